/* sv/pbic_pkg.sv */
// Package for the PRG bank / IRQ counter mapper: item and state types,
// window and bank-select codes, configuration indexes.
// No dependencies.
package pbic_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 48;

    // register windows, $8000..$F000
    localparam logic [2:0] WIN_RELOAD0 = 3'd0;
    localparam logic [2:0] WIN_RELOAD1 = 3'd1;
    localparam logic [2:0] WIN_RELOAD2 = 3'd2;
    localparam logic [2:0] WIN_RELOAD3 = 3'd3;
    localparam logic [2:0] WIN_CTRL    = 3'd4;
    localparam logic [2:0] WIN_ACK     = 3'd5;
    localparam logic [2:0] WIN_SELECT  = 3'd6;
    localparam logic [2:0] WIN_BANK    = 3'd7;

    // bank select codes
    localparam logic [2:0] SEL_BANK_FIRST = 3'd1;
    localparam logic [2:0] SEL_BANK_LAST  = 3'd4;
    localparam logic [2:0] SEL_ROM_6000   = 3'd5;

    localparam int          CTRL_ENABLE_BIT = 1;
    localparam int          ROM_SEL_BIT     = 2;
    localparam logic [15:0] COUNT_TERMINAL  = 16'hFFFF;
    localparam logic [7:0]  FIXED_LAST_BANK = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_AND_MASK  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OR_OFFSET = 8'd1;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_TICK  = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t      func;
        logic [2:0] reg_window;
        logic [7:0] write_data;
    } item_t;

    // mapping-visible state after an item
    typedef struct packed
    {
        logic            irq_line;
        logic            rom_at_6000;
        logic [3:0][7:0] bank_regs;
    } map_state_t;

    typedef struct packed
    {
        logic       irq_active;
        logic       low_window_is_rom;
        logic [7:0] bank_6000;
        logic [7:0] bank_8000;
        logic [7:0] bank_a000;
        logic [7:0] bank_c000;
        logic [7:0] bank_e000;
    } result_t;

endpackage

/* sv/pbic_core.sv */
// Mapper state: reload latch, IRQ counter, control, bank registers.
// Applies one item per fire and presents the post-item mapping state.
// Depends on pbic_pkg.
module pbic_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  pbic_pkg::item_t     item,
    output pbic_pkg::map_state_t state_next
);
    import pbic_pkg::*;

    logic [2:0]      bank_select_reg, bank_select_next;
    logic [3:0][7:0] bank_regs_reg, bank_regs_next;
    logic            rom_reg, rom_next;
    logic [7:0]      ctrl_reg, ctrl_next;
    logic [15:0]     count_reg, count_next;
    logic [15:0]     reload_reg, reload_next;
    logic            irq_reg, irq_next;
    logic [15:0]     count_inc;
    logic [1:0]      bank_idx;

    assign count_inc = count_reg + 16'd1;
    // only used for selects 1..4, so two bits cover it
    assign bank_idx  = bank_select_reg[1:0] - SEL_BANK_FIRST[1:0];

    always_comb
    begin
        bank_select_next = bank_select_reg;
        bank_regs_next   = bank_regs_reg;
        rom_next         = rom_reg;
        ctrl_next        = ctrl_reg;
        count_next       = count_reg;
        reload_next      = reload_reg;
        irq_next         = irq_reg;
        if (item.func == FUNC_TICK)
        begin
            if (ctrl_reg[CTRL_ENABLE_BIT])
            begin
                if (count_inc == COUNT_TERMINAL)
                begin
                    count_next                 = reload_reg;
                    ctrl_next[CTRL_ENABLE_BIT] = 1'b0;
                    irq_next                   = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
        else
        begin
            unique case (item.reg_window)
                WIN_RELOAD0, WIN_RELOAD1, WIN_RELOAD2, WIN_RELOAD3:
                begin
                    reload_next[{item.reg_window[1:0], 2'b00} +: 4] = item.write_data[3:0];
                end
                WIN_CTRL:
                begin
                    ctrl_next = item.write_data;
                    if (item.write_data[CTRL_ENABLE_BIT])
                    begin
                        count_next = reload_reg;
                    end
                    irq_next = 1'b0;
                end
                WIN_ACK:
                begin
                    irq_next = 1'b0;
                end
                WIN_SELECT:
                begin
                    bank_select_next = item.write_data[2:0];
                end
                WIN_BANK:
                begin
                    if (bank_select_reg >= SEL_BANK_FIRST && bank_select_reg <= SEL_BANK_LAST)
                    begin
                        bank_regs_next[bank_idx] = item.write_data;
                    end
                    else if (bank_select_reg == SEL_ROM_6000)
                    begin
                        rom_next = item.write_data[ROM_SEL_BIT];
                    end
                end
                default:
                begin
                    irq_next = irq_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg  <= 3'd0;
            bank_regs_reg[0] <= 8'd0;
            bank_regs_reg[1] <= 8'd1;
            bank_regs_reg[2] <= 8'd2;
            bank_regs_reg[3] <= 8'd3;
            rom_reg          <= 1'b0;
            ctrl_reg         <= 8'd0;
            count_reg        <= 16'd0;
            reload_reg       <= 16'd0;
            irq_reg          <= 1'b0;
        end
        else if (fire)
        begin
            bank_select_reg <= bank_select_next;
            bank_regs_reg   <= bank_regs_next;
            rom_reg         <= rom_next;
            ctrl_reg        <= ctrl_next;
            count_reg       <= count_next;
            reload_reg      <= reload_next;
            irq_reg         <= irq_next;
        end
    end

    assign state_next.irq_line    = irq_next;
    assign state_next.rom_at_6000 = rom_next;
    assign state_next.bank_regs   = bank_regs_next;

endmodule

/* sv/pbic_map.sv */
// Bank mapping: AND mask and OR offset applied to each 8 KB ROM window.
// Depends on pbic_pkg.
module pbic_map
(
    input  pbic_pkg::map_state_t state,
    input  logic [7:0]           and_mask,
    input  logic [7:0]           or_offset,
    output pbic_pkg::result_t    result
);
    import pbic_pkg::*;

    function automatic logic [7:0] map_bank(input logic [7:0] b, input logic [7:0] m,
                                            input logic [7:0] o);
        map_bank = (b & m) | o;
    endfunction

    always_comb
    begin
        result.irq_active        = state.irq_line;
        result.low_window_is_rom = state.rom_at_6000;
        // RAM at $6000 reads as bank 0
        result.bank_6000 = state.rom_at_6000 ?
                           map_bank(state.bank_regs[3], and_mask, or_offset) : 8'd0;
        result.bank_8000 = map_bank(state.bank_regs[0], and_mask, or_offset);
        result.bank_a000 = map_bank(state.bank_regs[1], and_mask, or_offset);
        result.bank_c000 = map_bank(state.bank_regs[2], and_mask, or_offset);
        result.bank_e000 = map_bank(FIXED_LAST_BANK, and_mask, or_offset);
    end

endmodule

/* sv/prg_bank_irq_counter_mapper.sv */
// Top level of the PRG bank / IRQ counter mapper: input beat register,
// result register, configuration registers.
// Depends on pbic_pkg, pbic_core, pbic_map.
//
// Usage:
//   s_*   : one beat per CPU event. tuser[0] = func (0 bus write, 1 CPU
//           cycle tick); tdata carries the window and the written byte.
//   m_*   : one result beat per input beat, carrying the IRQ line and the
//           five mapped 8 KB bank numbers as they stand after that event.
//   cfg_* : writes bank_and_mask (index 0) and bank_or_offset (index 1);
//           other indexes are dropped. Always ready. Write only while idle.
// Timing: a beat taken sits in the input register; its result is then
//   registered in the result register and offered on m_* from then on.
//   Throughput is one beat per cycle while the result register is free or
//   m_tready is high, set by the state update between the two registers.
// Stall: when m_tready is low the result register holds; the input register
//   still takes one more beat, then s_tready drops until the result moves.
// Reset: rst_n (async, low) clears both registers' valid flags, sets the
//   bank registers to 0,1,2,3, mask to 0xFF, offset, counter and IRQ to 0.
module prg_bank_irq_counter_mapper
(
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pbic_pkg::TDATA_IN_W-1:0]    s_tdata,  // [2:0] reg_window, [10:3] write_data
    input  logic [0:0]                         s_tuser,  // [0] func
    // master side
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] irq_active, [1] low_window_is_rom, [9:2] bank_6000, [17:10] bank_8000,
    // [25:18] bank_a000, [33:26] bank_c000, [41:34] bank_e000
    output logic [pbic_pkg::TDATA_OUT_W-1:0]   m_tdata,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pbic_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                         cfg_data
);
    import pbic_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    logic [7:0] mask_reg;
    logic [7:0] offset_reg;

    logic       advance;     // input beat moves into the result register
    map_state_t state_next;
    result_t    result_next;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.func       <= func_t'(s_tuser[0]);
            in_item_reg.reg_window <= s_tdata[2:0];
            in_item_reg.write_data <= s_tdata[10:3];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= 8'hFF;
            offset_reg <= 8'h00;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_AND_MASK)
            begin
                mask_reg <= cfg_data;
            end
            else if (cfg_index == CFG_OR_OFFSET)
            begin
                offset_reg <= cfg_data;
            end
        end
    end

    pbic_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (in_item_reg),
        .state_next (state_next)
    );

    pbic_map u_map
    (
        .state     (state_next),
        .and_mask  (mask_reg),
        .or_offset (offset_reg),
        .result    (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_result_reg.bank_e000,
                       out_result_reg.bank_c000,
                       out_result_reg.bank_a000,
                       out_result_reg.bank_8000,
                       out_result_reg.bank_6000,
                       out_result_reg.low_window_is_rom,
                       out_result_reg.irq_active};

endmodule

/* tb/prg_bank_irq_counter_mapper_tb.sv */
// Self-checking testbench for prg_bank_irq_counter_mapper: directed and random
// CPU write / tick traffic against a cycle-free shadow of the mapper state.
// Depends on pbic_pkg and the mapper RTL.
`timescale 1ns / 1ps

module prg_bank_irq_counter_mapper_tb;

    import pbic_pkg::*;

    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 64;      // long sink hold-off
    localparam int SETTLE_CYCLES = 8;       // pipe is two deep, give it margin
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_EVENTS = 960;     // phases overshoot by a timer run each
    localparam int PHASES        = 6;

    // sink stall patterns
    typedef enum int
    {
        SINK_OPEN,
        SINK_COIN,
        SINK_CADENCE,
        SINK_CHOKED
    } sink_mode_e;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata;   // [2:0] reg_window, [10:3] write_data
    logic [0:0]              s_tuser;   // [0] func
    logic                    m_tvalid;
    logic                    m_tready;
    // [0] irq_active, [1] low_window_is_rom, [9:2] bank_6000, [17:10] bank_8000,
    // [25:18] bank_a000, [33:26] bank_c000, [41:34] bank_e000
    logic [TDATA_OUT_W-1:0]  m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [7:0]              cfg_data;

    // shadow copy of the mapper state, reset values
    logic [2:0]       shadow_select = '0;
    logic [3:0][7:0]  shadow_banks  = {8'd3, 8'd2, 8'd1, 8'd0};
    logic             shadow_rom    = 1'b0;
    logic [7:0]       shadow_ctrl   = '0;
    logic [15:0]      shadow_count  = '0;
    logic [15:0]      shadow_reload = '0;
    logic             shadow_irq    = 1'b0;
    logic [7:0]       shadow_mask   = 8'hFF;
    logic [7:0]       shadow_offset = 8'h00;

    result_t expected_maps[$];

    int events_sent      = 0;
    int maps_checked     = 0;
    int mismatches       = 0;
    int irq_expiries     = 0;
    int settings_applied = 0;
    int cycle_count      = 0;
    int burst_left       = 0;
    int hold_asks        = 0;   // bumped by the stimulus, watched by the sink
    bit gaps_on          = 1'b1;

    prg_bank_irq_counter_mapper u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow mapper: one CPU event in, mapping as it stands afterwards out
    // ------------------------------------------------------------------
    function automatic logic [7:0] mask_and_offset(input logic [7:0] bank);
        return (bank & shadow_mask) | shadow_offset;
    endfunction

    function automatic result_t advance_mapper(input item_t ev);
        result_t r;
        if (ev.func == FUNC_TICK)
        begin
            // counter only runs while the enable bit is set
            if (shadow_ctrl[CTRL_ENABLE_BIT])
            begin
                shadow_count = shadow_count + 16'd1;
                if (shadow_count == COUNT_TERMINAL)
                begin
                    shadow_count = shadow_reload;
                    shadow_ctrl[CTRL_ENABLE_BIT] = 1'b0;
                    shadow_irq = 1'b1;
                    irq_expiries++;
                end
            end
        end
        else
        begin
            case (ev.reg_window)
                WIN_RELOAD0, WIN_RELOAD1, WIN_RELOAD2, WIN_RELOAD3:
                    shadow_reload[ev.reg_window[1:0] * 4 +: 4] = ev.write_data[3:0];
                WIN_CTRL:
                begin
                    shadow_ctrl = ev.write_data;
                    if (shadow_ctrl[CTRL_ENABLE_BIT])
                        shadow_count = shadow_reload;
                    shadow_irq = 1'b0;
                end
                WIN_ACK:
                    shadow_irq = 1'b0;
                WIN_SELECT:
                    shadow_select = ev.write_data[2:0];
                default:
                begin
                    // WIN_BANK: target depends on the last select; 0, 6, 7 drop it
                    if (shadow_select >= SEL_BANK_FIRST && shadow_select <= SEL_BANK_LAST)
                        shadow_banks[shadow_select - SEL_BANK_FIRST] = ev.write_data;
                    else if (shadow_select == SEL_ROM_6000)
                        shadow_rom = ev.write_data[ROM_SEL_BIT];
                end
            endcase
        end
        r.irq_active        = shadow_irq;
        r.low_window_is_rom = shadow_rom;
        // $6000 shows bank reg 3 only with ROM selected, RAM bank 0 otherwise
        r.bank_6000 = shadow_rom ? mask_and_offset(shadow_banks[3]) : 8'd0;
        r.bank_8000 = mask_and_offset(shadow_banks[0]);
        r.bank_a000 = mask_and_offset(shadow_banks[1]);
        r.bank_c000 = mask_and_offset(shadow_banks[2]);
        r.bank_e000 = mask_and_offset(FIXED_LAST_BANK);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Source side: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    task automatic send_event(input func_t f, input logic [2:0] win, input logic [7:0] data);
        item_t ev;
        ev.func       = f;
        ev.reg_window = win;
        ev.write_data = data;
        if (burst_left == 0)
        begin
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            if (gaps_on)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_IN_W'({ev.write_data, ev.reg_window});
        s_tuser  <= ev.func;
        do @(posedge clk); while (!s_tready);
        expected_maps.push_back(advance_mapper(ev));
        events_sent++;
    endtask

    // source goes quiet until every result is back and the pipe is empty
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_maps.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_mapper_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_AND_MASK)
            shadow_mask = val;
        else if (idx == CFG_OR_OFFSET)
            shadow_offset = val;
    endtask

    // idle the mapper, set mask/offset, and poke an undecoded index as well
    task automatic program_mapping(input logic [7:0] mask, input logic [7:0] offset);
        wait_for_results();
        write_mapper_reg(CFG_AND_MASK, mask);
        write_mapper_reg(CFG_OR_OFFSET, offset);
        write_mapper_reg(CFG_INDEX_W'($urandom_range(CFG_OR_OFFSET + 1, 255)), 8'($urandom));
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    task automatic test_reset_view();
        program_mapping(8'hFF, 8'h00);
        send_event(FUNC_TICK, WIN_BANK, 8'hFF);      // counter off, fields ignored
        send_event(FUNC_WRITE, WIN_ACK, 8'h00);      // ack with nothing pending
        send_event(FUNC_WRITE, WIN_SELECT, 8'hF8);   // select 0
        send_event(FUNC_WRITE, WIN_BANK, 8'hFF);     // dropped
    endtask

    task automatic test_bank_windows();
        logic [7:0] fill [4];
        fill = '{8'hFF, 8'h00, 8'h80, 8'h7F};
        for (int b = 0; b < 4; b++)
        begin
            // junk in the upper select bits must not matter
            send_event(FUNC_WRITE, WIN_SELECT, {5'h1F, 3'(SEL_BANK_FIRST + b)});
            send_event(FUNC_WRITE, WIN_BANK, fill[b]);
        end
        send_event(FUNC_WRITE, WIN_SELECT, {5'h00, SEL_ROM_6000});
        send_event(FUNC_WRITE, WIN_BANK, 8'hFB);     // ROM bit clear: RAM stays
        send_event(FUNC_WRITE, WIN_BANK, 8'h04);     // ROM at $6000
        send_event(FUNC_WRITE, WIN_SELECT, 8'h07);
        send_event(FUNC_WRITE, WIN_BANK, 8'h00);     // dropped
    endtask

    task automatic test_irq_counter();
        send_event(FUNC_WRITE, WIN_RELOAD0, 8'hED);  // upper nibbles are junk
        send_event(FUNC_WRITE, WIN_RELOAD1, 8'h5F);
        send_event(FUNC_WRITE, WIN_RELOAD2, 8'hAF);
        send_event(FUNC_WRITE, WIN_RELOAD3, 8'hFF);  // reload = FFFD
        send_event(FUNC_WRITE, WIN_CTRL, 8'h02);     // enable and load
        send_event(FUNC_TICK, WIN_BANK, 8'hFF);
        send_event(FUNC_TICK, WIN_RELOAD0, 8'h00);   // hits terminal: IRQ
        send_event(FUNC_TICK, WIN_CTRL, 8'h02);      // stopped now
        send_event(FUNC_WRITE, WIN_ACK, 8'hFF);
        // reload at terminal: the next tick wraps the counter to zero
        send_event(FUNC_WRITE, WIN_RELOAD0, 8'h0F);
        send_event(FUNC_WRITE, WIN_CTRL, 8'hFF);
        send_event(FUNC_TICK, WIN_SELECT, 8'h55);
        send_event(FUNC_WRITE, WIN_CTRL, 8'hFD);
    endtask

    // sink holds off while the source keeps pushing, then source drains
    task automatic test_backpressure();
        wait_for_results();
        gaps_on = 1'b0;
        hold_asks <= hold_asks + 1;
        repeat (24)
            send_event(func_t'($urandom_range(0, 1)), 3'($urandom), 8'($urandom));
        gaps_on = 1'b1;
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Random sequences
    // ------------------------------------------------------------------
    task automatic random_timer_run();
        logic [15:0] reload;
        logic [7:0]  ctrl;
        int          span;
        span   = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 24);
        reload = COUNT_TERMINAL - 16'(span);
        for (int n = 0; n < 4; n++)
            send_event(FUNC_WRITE, 3'(WIN_RELOAD0 + n), {4'($urandom), reload[n * 4 +: 4]});
        ctrl = 8'($urandom);
        ctrl[CTRL_ENABLE_BIT] = 1'b1;
        send_event(FUNC_WRITE, WIN_CTRL, ctrl);
        for (int t = 0; t < span + $urandom_range(0, 5); t++)
        begin
            case ($urandom_range(0, 29))
                0: send_event(FUNC_WRITE, 3'($urandom_range(WIN_RELOAD0, WIN_RELOAD3)),
                              8'($urandom));                      // latch moves mid-count
                1: send_event(FUNC_WRITE, WIN_CTRL, 8'($urandom)); // broken run
                2: send_event(FUNC_WRITE, WIN_ACK, 8'($urandom));
                3: send_event(FUNC_WRITE, 3'($urandom_range(WIN_SELECT, WIN_BANK)),
                              8'($urandom));
                default: send_event(FUNC_TICK, 3'($urandom), 8'($urandom));
            endcase
        end
        if ($urandom_range(0, 1))
            send_event(FUNC_WRITE, WIN_ACK, 8'($urandom));
        else
            send_event(FUNC_WRITE, WIN_CTRL, 8'($urandom));
    endtask

    task automatic random_bank_program();
        logic [2:0] sel;
        sel = ($urandom_range(0, 4) == 0) ? 3'($urandom)
                                          : 3'($urandom_range(SEL_BANK_FIRST, SEL_ROM_6000));
        send_event(FUNC_WRITE, WIN_SELECT, {5'($urandom), sel});
        repeat ($urandom_range(1, 3))
            send_event(FUNC_WRITE, WIN_BANK, 8'($urandom));
    endtask

    task automatic test_random_traffic();
        logic [7:0] masks   [PHASES];
        logic [7:0] offsets [PHASES];
        int         phase_end;
        int         pick;
        masks   = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h00, 8'hFF};
        offsets = '{8'h00, 8'hFF, 8'hA0, 8'h05, 8'h00, 8'h00};
        masks[4]   = 8'($urandom);
        offsets[4] = 8'($urandom);
        for (int p = 0; p < PHASES; p++)
        begin
            program_mapping(masks[p], offsets[p]);
            phase_end = events_sent + RANDOM_EVENTS / PHASES;
            while (events_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    random_timer_run();
                else if (pick < 70)
                    random_bank_program();
                else if (pick < 85)
                    repeat ($urandom_range(1, 10))
                        send_event(FUNC_TICK, 3'($urandom), 8'($urandom));
                else
                    repeat ($urandom_range(1, 4))
                        send_event(func_t'($urandom_range(0, 1)), 3'($urandom), 8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sink side: its own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : sink_stalls
        sink_mode_e mode;
        int         mode_left;
        int         hold_left;
        int         hold_seen;
        int         tick;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        tick      = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_e'($urandom_range(SINK_OPEN, SINK_CHOKED));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:    m_tready <= 1'b1;
                    SINK_COIN:    m_tready <= 1'($urandom_range(0, 1));
                    SINK_CADENCE: m_tready <= (tick % 4) != 3;
                    default:      m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every beat against the oldest expected mapping
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_maps
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.irq_active        = m_tdata[0];
            got.low_window_is_rom = m_tdata[1];
            got.bank_6000         = m_tdata[9:2];
            got.bank_8000         = m_tdata[17:10];
            got.bank_a000         = m_tdata[25:18];
            got.bank_c000         = m_tdata[33:26];
            got.bank_e000         = m_tdata[41:34];
            maps_checked++;
            if (expected_maps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result beat %h with nothing pending", m_tdata);
            end
            else
            begin
                want = expected_maps.pop_front();
                if (got.irq_active !== want.irq_active ||
                    got.low_window_is_rom !== want.low_window_is_rom ||
                    got.bank_6000 !== want.bank_6000 || got.bank_8000 !== want.bank_8000 ||
                    got.bank_a000 !== want.bank_a000 || got.bank_c000 !== want.bank_c000 ||
                    got.bank_e000 !== want.bank_e000)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"ERROR: beat %0d exp/got irq %b/%b rom %b/%b 6000 %h/%h ",
                                  "8000 %h/%h a000 %h/%h c000 %h/%h e000 %h/%h"},
                                 maps_checked, want.irq_active, got.irq_active,
                                 want.low_window_is_rom, got.low_window_is_rom,
                                 want.bank_6000, got.bank_6000, want.bank_8000, got.bank_8000,
                                 want.bank_a000, got.bank_a000, want.bank_c000, got.bank_c000,
                                 want.bank_e000, got.bank_e000);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ERROR: timeout after %0d cycles, %0d results pending",
                 cycle_count, expected_maps.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_view();
        test_bank_windows();
        test_irq_counter();
        test_backpressure();
        test_random_traffic();
        wait_for_results();

        $display("Covered %0d CPU events with %0d counter expiries, %0d mapping beats checked",
                 events_sent, irq_expiries, maps_checked);
        $display("over %0d mask/offset settings; %0d mismatches",
                 settings_applied, mismatches);
        if (mismatches == 0 && expected_maps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
